### design/scheduled_spindle_pwm_queue_unit_defines.svh
// Assertion macros for the scheduled spindle PWM queue unit.
// Used by files that check their logic; needs i_clk and i_rst_n in scope.
`ifndef SCHEDULED_SPINDLE_PWM_QUEUE_UNIT_DEFINES_SVH
`define SCHEDULED_SPINDLE_PWM_QUEUE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SSPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SSPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SSPQ_ASSERT(label, prop, msg)
`define SSPQ_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

### design/sspq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the scheduled spindle PWM queue unit.
// No dependencies.
package sspq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF     = 16;
    localparam int unsigned SCHEDULE_OFFSET_DEF = 8;

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [15:0] FULL_ON = 16'hFFFF;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_MIN_DUTY  = 2'd0;
    localparam logic [1:0] REG_MAX_DUTY  = 2'd1;
    localparam logic [1:0] REG_TIMER_TOP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET,
        ST_TICK_RD,
        ST_TICK_CHK
    } t_state;

    // one queued command
    typedef struct packed {
        logic [7:0]  stamp;
        logic [15:0] compare;
        logic        clockwise;
    } t_entry;

    // result of the speed-to-compare pipeline
    typedef struct packed {
        logic        valid;
        logic [14:0] speed_abs;
        logic [14:0] duty;
        logic [15:0] compare;
        logic        clockwise;
    } t_duty_res;

endpackage

### design/sspq_duty.sv
`timescale 1ns / 1ps
// Three-stage pipeline: signed Q1.14 speed to duty and timer compare value.
// Depends on sspq_pkg.
module sspq_duty (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [15:0]    i_speed,
    input  logic [14:0]           i_min_duty,
    input  logic [14:0]           i_max_duty,
    input  logic [15:0]           i_timer_top,
    output sspq_pkg::t_duty_res   o_res
);

    logic [15:0] mag;
    logic [14:0] s_sat;
    logic [14:0] mn_sat;
    logic [14:0] mx_sat;
    logic [14:0] s_comp;

    logic        r_v1;
    logic [29:0] r_p1;
    logic [29:0] r_p2;
    logic [14:0] r_s1;
    logic        r_mx_full;
    logic        r_cw1;

    logic [30:0] sum;
    logic [14:0] duty2;

    logic        r_v2;
    logic [14:0] r_s2;
    logic [14:0] r_duty2;
    logic        r_cw2;

    logic [30:0] prod3;
    logic [15:0] cmp3;

    logic        r_v3;
    logic [14:0] r_s3;
    logic [14:0] r_duty3;
    logic [15:0] r_cmp3;
    logic        r_cw3;

    // stage 1: magnitude, saturation, weighted products
    always_comb begin
        mag    = i_speed[15] ? (16'd0 - i_speed) : i_speed;
        s_sat  = (mag > 16'(sspq_pkg::ONE_Q14)) ? sspq_pkg::ONE_Q14 : mag[14:0];
        mn_sat = (i_min_duty > sspq_pkg::ONE_Q14) ? sspq_pkg::ONE_Q14 : i_min_duty;
        mx_sat = (i_max_duty > sspq_pkg::ONE_Q14) ? sspq_pkg::ONE_Q14 : i_max_duty;
        s_comp = sspq_pkg::ONE_Q14 - s_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1      <= 30'(s_sat) * 30'(mx_sat);
        r_p2      <= 30'(s_comp) * 30'(mn_sat);
        r_s1      <= s_sat;
        r_mx_full <= (mx_sat == sspq_pkg::ONE_Q14);
        r_cw1     <= !i_speed[15] && (i_speed != 16'sd0);
    end

    // stage 2: blend and scale back to Q1.14
    always_comb begin
        sum = 31'(r_p1) + 31'(r_p2);
        if (r_s1 == 15'd0) begin
            duty2 = 15'd0;
        end else if (r_s1 == sspq_pkg::ONE_Q14 && r_mx_full) begin
            duty2 = sspq_pkg::ONE_Q14;
        end else begin
            duty2 = sum[28:14];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2    <= r_s1;
        r_duty2 <= duty2;
        r_cw2   <= r_cw1;
    end

    // stage 3: scale the duty into the timer period
    always_comb begin
        prod3 = 31'(i_timer_top) * 31'(r_duty2);
        if (r_duty2 == 15'd0) begin
            cmp3 = 16'd0;
        end else if (r_duty2 >= sspq_pkg::ONE_Q14) begin
            cmp3 = sspq_pkg::FULL_ON;
        end else begin
            cmp3 = prod3[29:14];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3    <= r_s2;
        r_duty3 <= r_duty2;
        r_cmp3  <= cmp3;
        r_cw3   <= r_cw2;
    end

    assign o_res.valid     = r_v3;
    assign o_res.speed_abs = r_s3;
    assign o_res.duty      = r_duty3;
    assign o_res.compare   = r_cmp3;
    assign o_res.clockwise = r_cw3;

endmodule

### design/sspq_mem.sv
`timescale 1ns / 1ps
// Command queue storage: one write port, one read port with registered data.
// Depends on sspq_pkg.
module sspq_mem #(
    parameter int unsigned DEPTH = sspq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  sspq_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output sspq_pkg::t_entry      o_rdata
);

    sspq_pkg::t_entry r_mem [DEPTH];
    sspq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/scheduled_spindle_pwm_queue_unit.sv
`timescale 1ns / 1ps
// Scheduled spindle PWM queue unit. Accepts a command when start is high and busy
// is low, and answers every command with exactly one result, shown for a single
// cycle while o_valid is high; the receiver cannot stall, so sample it then.
// A set command passes through the three-stage multiply pipeline that turns speed into
// duty and compare value, and then writes its entry into the queue. A tick reads the
// queue head through the registered read port of the memory, then checks and pops one
// entry per cycle while the head entry is due. The user must send configuration
// through the APB port only while no command is in flight; the block does not enforce it.
// Depends on sspq_pkg, sspq_duty, sspq_mem and the defines header.
`include "scheduled_spindle_pwm_queue_unit_defines.svh"
module scheduled_spindle_pwm_queue_unit #(
    parameter int unsigned QUEUE_DEPTH     = sspq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned SCHEDULE_OFFSET = sspq_pkg::SCHEDULE_OFFSET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [7:0]         i_delay,
    input  logic signed [15:0] i_speed,
    input  logic               i_estop,
    // result channel
    output logic               o_valid,
    output logic               o_enable,
    output logic               o_full_on,
    output logic [15:0]        o_compare_value,
    output logic               o_reverse,
    output logic               o_applied,
    output logic               o_queue_cleared,
    output logic [14:0]        o_speed_readback,
    output logic [14:0]        o_duty_readback,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    sspq_pkg::t_state r_state;
    sspq_pkg::t_state n_state;

    logic [14:0] r_min_duty;
    logic [14:0] r_max_duty;
    logic [15:0] r_timer_top;

    logic [7:0]    r_delay;
    logic          r_estop;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [7:0]    r_now;
    logic [14:0]   r_last_speed;
    logic [14:0]   r_last_duty;
    logic [15:0]   r_out_compare;
    logic          r_out_reverse;
    logic          r_applied;
    logic          r_cleared;
    logic          r_done;
    logic          r_tk_hit;
    logic [15:0]   r_tk_cmp;
    logic          r_tk_cw;

    logic accept;
    logic cfg_write;

    sspq_pkg::t_duty_res duty_res;
    sspq_pkg::t_entry    wr_entry;
    sspq_pkg::t_entry    rd_entry;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          set_fin;
    logic          tick_fin;
    logic          pop;

    logic          q_full;
    logic [SW-1:0] slot_sum;
    logic [SW-1:0] slot_wrap;
    logic [AW-1:0] head_next;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty  <= 15'd0;
            r_max_duty  <= 15'd0;
            r_timer_top <= 16'd0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                sspq_pkg::REG_MIN_DUTY:  r_min_duty  <= pwdata[14:0];
                sspq_pkg::REG_MAX_DUTY:  r_max_duty  <= pwdata[14:0];
                sspq_pkg::REG_TIMER_TOP: r_timer_top <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sspq_pkg::REG_MIN_DUTY:  prdata = 32'(r_min_duty);
            sspq_pkg::REG_MAX_DUTY:  prdata = 32'(r_max_duty);
            sspq_pkg::REG_TIMER_TOP: prdata = 32'(r_timer_top);
            default:                 prdata = 32'd0;
        endcase
    end

    sspq_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && (i_opcode == sspq_pkg::OP_SET)),
        .i_speed     (i_speed),
        .i_min_duty  (r_min_duty),
        .i_max_duty  (r_max_duty),
        .i_timer_top (r_timer_top),
        .o_res       (duty_res)
    );

    sspq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_entry),
        .i_raddr (mem_raddr),
        .o_rdata (rd_entry)
    );

    // queue address arithmetic
    always_comb begin
        q_full    = (r_count == CW'(QUEUE_DEPTH));
        slot_sum  = SW'(r_head) + SW'(r_count);
        slot_wrap = (slot_sum >= SW'(QUEUE_DEPTH)) ? (slot_sum - SW'(QUEUE_DEPTH)) : slot_sum;
        head_next = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        pop       = (r_count != '0) && (rd_entry.stamp == r_now);
    end

    always_comb begin
        wr_entry.stamp     = r_now + r_delay + 8'(SCHEDULE_OFFSET);
        wr_entry.compare   = duty_res.compare;
        wr_entry.clockwise = duty_res.clockwise;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sspq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == sspq_pkg::OP_TICK) ? sspq_pkg::ST_TICK_RD
                                                              : sspq_pkg::ST_SET;
                end
            end
            sspq_pkg::ST_SET: begin
                if (duty_res.valid) begin
                    n_state = sspq_pkg::ST_IDLE;
                end
            end
            sspq_pkg::ST_TICK_RD:  n_state = sspq_pkg::ST_TICK_CHK;
            sspq_pkg::ST_TICK_CHK: begin
                if (!pop) begin
                    n_state = sspq_pkg::ST_IDLE;
                end
            end
            default: n_state = sspq_pkg::ST_IDLE;
        endcase
    end

    // state outputs and memory control
    always_comb begin
        busy      = 1'b1;
        set_fin   = 1'b0;
        tick_fin  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = q_full ? '0 : slot_wrap[AW-1:0];
        mem_raddr = r_head;
        case (r_state)
            sspq_pkg::ST_IDLE: busy = 1'b0;
            sspq_pkg::ST_SET: begin
                set_fin = duty_res.valid;
                mem_we  = duty_res.valid;
            end
            sspq_pkg::ST_TICK_RD: mem_raddr = r_head;
            sspq_pkg::ST_TICK_CHK: begin
                // fetch the following entry while this one pops
                mem_raddr = pop ? head_next : r_head;
                tick_fin  = !pop;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_delay <= i_delay;
            r_estop <= i_estop;
        end
    end

    // queue pointers, tick count and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_now         <= 8'd0;
            r_last_speed  <= 15'd0;
            r_last_duty   <= 15'd0;
            r_out_compare <= 16'd0;
            r_out_reverse <= 1'b0;
            r_applied     <= 1'b0;
            r_cleared     <= 1'b0;
            r_done        <= 1'b0;
            r_tk_hit      <= 1'b0;
            r_tk_cmp      <= 16'd0;
            r_tk_cw       <= 1'b1;
        end else begin
            r_done <= set_fin || tick_fin;
            if (accept) begin
                r_tk_hit <= 1'b0;
            end
            if (set_fin) begin
                if (q_full) begin
                    r_head  <= '0;
                    r_count <= CW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
                r_cleared    <= q_full;
                r_applied    <= 1'b0;
                r_last_speed <= duty_res.speed_abs;
                r_last_duty  <= duty_res.duty;
            end
            if (r_state == sspq_pkg::ST_TICK_CHK && pop) begin
                r_head   <= head_next;
                r_count  <= r_count - CW'(1);
                r_tk_hit <= 1'b1;
                r_tk_cmp <= rd_entry.compare;
                r_tk_cw  <= rd_entry.clockwise;
            end
            if (tick_fin) begin
                r_applied <= r_tk_hit;
                r_cleared <= 1'b0;
                r_now     <= r_now + 8'd1;
                if (r_tk_hit) begin
                    r_out_compare <= r_estop ? 16'd0 : r_tk_cmp;
                    if (r_tk_cmp != 16'd0) begin
                        r_out_reverse <= !r_tk_cw;
                    end
                end
            end
        end
    end

    assign o_valid          = r_done;
    assign o_enable         = (r_out_compare != 16'd0);
    assign o_full_on        = (r_out_compare == sspq_pkg::FULL_ON);
    assign o_compare_value  = r_out_compare;
    assign o_reverse        = r_out_reverse;
    assign o_applied        = r_applied;
    assign o_queue_cleared  = r_cleared;
    assign o_speed_readback = r_last_speed;
    assign o_duty_readback  = r_last_duty;

    `SSPQ_ASSERT(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "queue count above depth")
    `SSPQ_ASSERT_IMP(a_done_after_work, r_done, $past(r_state) != sspq_pkg::ST_IDLE, "result without work")
    `SSPQ_ASSERT_IMP(a_write_only_set, mem_we, r_state == sspq_pkg::ST_SET, "queue write outside set")
    `SSPQ_ASSERT_IMP(a_flags_exclusive, r_done, !(r_applied && r_cleared), "applied and cleared together")

endmodule
